// File: hw/rtl/dtcs_pkg.sv
// ----------------------------------------------------------------------------
// dtcs_pkg
// Shared constants, types and helpers for the dense to coordinate sparse unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dtcs_pkg;

    // Sizing
    localparam int MAX_DIM     = 64;
    localparam int VALUE_BITS  = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CFG_W       = 7;
    localparam int IDX_W       = 1;
    localparam int OUT_W       = 32;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    typedef enum logic [1:0] {
        KIND_NOT_READY  = 2'd0,
        KIND_HEADER     = 2'd1,
        KIND_TRIPLET    = 2'd2,
        KIND_NOT_SPARSE = 2'd3
    } dtcs_kind_t;

    typedef enum logic [1:0] {
        PH_LOAD       = 2'd0,
        PH_HEADER     = 2'd1,
        PH_TRIPLET    = 2'd2,
        PH_NOT_SPARSE = 2'd3
    } dtcs_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_CHECK = 2'd2
    } dtcs_state_t;

    // Effective matrix shape, handed from the register block to the control
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [CNT_W-1:0] total;
    } dtcs_dims_t;

    // Map an out-of-range dimension onto 1..MAX_DIM
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (32'(v) > MAX_DIM)
            r = CFG_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    // Keep the low VALUE_BITS of an input element (sign extended if wider)
    function automatic logic [VALUE_BITS-1:0] to_kept(input logic signed [OUT_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[VALUE_BITS-1:0];
    endfunction

    // Sign extend a kept element and take its low 32 bits for the result port
    function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_BITS-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dtcs_ram.sv
// ----------------------------------------------------------------------------
// dtcs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/dtcs_cfg.sv
// ----------------------------------------------------------------------------
// dtcs_cfg
// Shape registers: hold row and column counts, clamp them, form element total.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcs_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [dtcs_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [dtcs_pkg::CFG_W-1:0]     cfg_data,
    output dtcs_pkg::dtcs_dims_t                dims,
    output logic                                cfg_hit
);

    logic [dtcs_pkg::CFG_W-1:0] row_count_reg;
    logic [dtcs_pkg::CFG_W-1:0] row_count_next;
    logic [dtcs_pkg::CFG_W-1:0] column_count_reg;
    logic [dtcs_pkg::CFG_W-1:0] column_count_next;
    logic [dtcs_pkg::CFG_W-1:0] rows_eff;
    logic [dtcs_pkg::CFG_W-1:0] cols_eff;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dtcs_pkg::REG_ROW_COUNT:    row_count_next    = cfg_data;
                dtcs_pkg::REG_COLUMN_COUNT: column_count_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= dtcs_pkg::CFG_W'(1);
            column_count_reg <= dtcs_pkg::CFG_W'(1);
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    assign rows_eff   = dtcs_pkg::clamp_dim(row_count_reg);
    assign cols_eff   = dtcs_pkg::clamp_dim(column_count_reg);
    assign dims.rows  = rows_eff;
    assign dims.cols  = cols_eff;
    assign dims.total = dtcs_pkg::CNT_W'(rows_eff) * dtcs_pkg::CNT_W'(cols_eff);
    // every write abandons the matrix in progress
    assign cfg_hit    = cfg_write;

endmodule

`default_nettype wire

// File: hw/rtl/dense_to_coordinate_sparse_unit.sv
// ----------------------------------------------------------------------------
// dense_to_coordinate_sparse_unit
// Loads a dense matrix row-major into an element RAM, then reads it out on
// request as a header plus coordinate triplets, or a single not-sparse report.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   command  | start in, busy out         | command, element_value
//   result   | done out (one-cycle pulse) | kind, row_field, column_field,
//            |                            | value_field, last
//   config   | cfg_write in               | cfg_index, cfg_data
//
// A load is written straight into the RAM; busy stays low.
// Header, not-ready and not-sparse pulls are answered from idle; done pulses
// in the cycle after the pull is accepted. A triplet pull holds busy for one
// RAM fetch, then one check per entry, skipping zero entries, and pulses done
// as busy falls. The receiver cannot stall.
// Reset is asynchronous, active low; the RAM is never cleared.
//
`default_nettype none

module dense_to_coordinate_sparse_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           command,
    input  wire logic signed [31:0]             element_value,
    // result channel
    output logic                                done,
    output logic [1:0]                          kind,
    output logic [6:0]                          row_field,
    output logic [6:0]                          column_field,
    output logic signed [31:0]                  value_field,
    output logic                                last,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic [dtcs_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [dtcs_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CNT_W  = dtcs_pkg::CNT_W;
    localparam int ADDR_W = dtcs_pkg::ADDR_W;
    localparam int CFG_W  = dtcs_pkg::CFG_W;
    localparam int VB     = dtcs_pkg::VALUE_BITS;
    localparam int OUT_W  = dtcs_pkg::OUT_W;

    dtcs_pkg::dtcs_dims_t  dims;
    logic                  cfg_hit;

    // control state
    dtcs_pkg::dtcs_state_t state_reg,  state_next;
    dtcs_pkg::dtcs_phase_t phase_reg,  phase_next;
    logic [CNT_W-1:0]      loaded_reg, loaded_next;
    logic [CNT_W-1:0]      zeros_reg,  zeros_next;
    logic [CNT_W-1:0]      scan_pos_reg, scan_pos_next;
    logic [CFG_W-1:0]      scan_row_reg, scan_row_next;
    logic [CFG_W-1:0]      scan_col_reg, scan_col_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic                  done_reg,   done_next;

    // result payload
    dtcs_pkg::dtcs_kind_t  kind_reg,   kind_next;
    logic [CFG_W-1:0]      row_reg,    row_next;
    logic [CFG_W-1:0]      col_reg,    col_next;
    logic [OUT_W-1:0]      value_reg,  value_next;
    logic                  last_reg,   last_next;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VB-1:0]         ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [VB-1:0]         ram_rdata;

    logic                  accept;
    logic [VB-1:0]         kept;
    logic [CNT_W-1:0]      nonzero_cnt;
    logic [CNT_W-1:0]      pos_inc;

    dtcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims),
        .cfg_hit   (cfg_hit)
    );

    dtcs_ram #(
        .WIDTH  (VB),
        .DEPTH  (dtcs_pkg::STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != dtcs_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign kept        = dtcs_pkg::to_kept(element_value);
    assign nonzero_cnt = dims.total - zeros_reg;
    assign pos_inc     = scan_pos_reg + CNT_W'(1);

    // Next state, RAM control and result formation
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        loaded_next   = loaded_reg;
        zeros_next    = zeros_reg;
        scan_pos_next = scan_pos_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        remain_next   = remain_reg;
        done_next     = 1'b0;
        kind_next     = kind_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = loaded_reg[ADDR_W-1:0];
        ram_wdata     = kept;
        ram_raddr     = scan_pos_reg[ADDR_W-1:0];

        if (cfg_hit)
        begin
            // drop any matrix in progress
            state_next  = dtcs_pkg::ST_IDLE;
            phase_next  = dtcs_pkg::PH_LOAD;
            loaded_next = '0;
            zeros_next  = '0;
            scan_pos_next = '0;
        end
        else
        begin
            unique case (state_reg)
                dtcs_pkg::ST_IDLE:
                begin
                    if (accept && command == dtcs_pkg::CMD_LOAD)
                    begin
                        // loads outside the load phase are ignored
                        if (phase_reg == dtcs_pkg::PH_LOAD)
                        begin
                            ram_we      = 1'b1;
                            loaded_next = loaded_reg + CNT_W'(1);
                            zeros_next  = zeros_reg + CNT_W'(kept == '0);
                            if (loaded_next >= dims.total)
                            begin
                                phase_next = (zeros_next >= (dims.total >> 1))
                                           ? dtcs_pkg::PH_HEADER
                                           : dtcs_pkg::PH_NOT_SPARSE;
                            end
                        end
                    end
                    else if (accept && command == dtcs_pkg::CMD_PULL)
                    begin
                        unique case (phase_reg)
                            dtcs_pkg::PH_LOAD:
                            begin
                                done_next  = 1'b1;
                                kind_next  = dtcs_pkg::KIND_NOT_READY;
                                row_next   = '0;
                                col_next   = '0;
                                value_next = '0;
                                last_next  = 1'b0;
                            end
                            dtcs_pkg::PH_HEADER:
                            begin
                                done_next  = 1'b1;
                                kind_next  = dtcs_pkg::KIND_HEADER;
                                row_next   = dims.rows;
                                col_next   = dims.cols;
                                value_next = OUT_W'(nonzero_cnt);
                                if (nonzero_cnt == '0)
                                begin
                                    // empty list: header is the final report
                                    last_next   = 1'b1;
                                    phase_next  = dtcs_pkg::PH_LOAD;
                                    loaded_next = '0;
                                    zeros_next  = '0;
                                end
                                else
                                begin
                                    last_next     = 1'b0;
                                    phase_next    = dtcs_pkg::PH_TRIPLET;
                                    scan_pos_next = '0;
                                    scan_row_next = '0;
                                    scan_col_next = '0;
                                    remain_next   = nonzero_cnt;
                                end
                            end
                            dtcs_pkg::PH_TRIPLET:
                            begin
                                state_next = dtcs_pkg::ST_FETCH;
                            end
                            dtcs_pkg::PH_NOT_SPARSE:
                            begin
                                done_next   = 1'b1;
                                kind_next   = dtcs_pkg::KIND_NOT_SPARSE;
                                row_next    = '0;
                                col_next    = '0;
                                value_next  = '0;
                                last_next   = 1'b1;
                                phase_next  = dtcs_pkg::PH_LOAD;
                                loaded_next = '0;
                                zeros_next  = '0;
                            end
                            default: ;
                        endcase
                    end
                end

                dtcs_pkg::ST_FETCH:
                begin
                    // read for scan_pos issued this cycle
                    state_next = dtcs_pkg::ST_CHECK;
                end

                dtcs_pkg::ST_CHECK:
                begin
                    // data for scan_pos is back; fetch the following entry
                    ram_raddr     = pos_inc[ADDR_W-1:0];
                    scan_pos_next = pos_inc;
                    if (scan_col_reg + CFG_W'(1) == dims.cols)
                    begin
                        scan_col_next = '0;
                        scan_row_next = scan_row_reg + CFG_W'(1);
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + CFG_W'(1);
                    end

                    if (ram_rdata != '0)
                    begin
                        done_next   = 1'b1;
                        kind_next   = dtcs_pkg::KIND_TRIPLET;
                        row_next    = scan_row_reg;
                        col_next    = scan_col_reg;
                        value_next  = dtcs_pkg::to_out(ram_rdata);
                        remain_next = remain_reg - CNT_W'(1);
                        state_next  = dtcs_pkg::ST_IDLE;
                        if (remain_reg == CNT_W'(1))
                        begin
                            last_next   = 1'b1;
                            phase_next  = dtcs_pkg::PH_LOAD;
                            loaded_next = '0;
                            zeros_next  = '0;
                        end
                        else
                        begin
                            last_next = 1'b0;
                        end
                    end
                end

                default:
                begin
                    state_next = dtcs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dtcs_pkg::ST_IDLE;
            phase_reg    <= dtcs_pkg::PH_LOAD;
            loaded_reg   <= '0;
            zeros_reg    <= '0;
            scan_pos_reg <= '0;
            scan_row_reg <= '0;
            scan_col_reg <= '0;
            remain_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            loaded_reg   <= loaded_next;
            zeros_reg    <= zeros_next;
            scan_pos_reg <= scan_pos_next;
            scan_row_reg <= scan_row_next;
            scan_col_reg <= scan_col_next;
            remain_reg   <= remain_next;
            done_reg     <= done_next;
        end
    end

    // Result payload: no reset, qualified by done
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign done         = done_reg;
    assign kind         = kind_reg;
    assign row_field    = row_reg;
    assign column_field = col_reg;
    assign value_field  = signed'(value_reg);
    assign last         = last_reg;

    // A result only follows an accepted command or a completed scan
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept) || $past(state_reg == dtcs_pkg::ST_CHECK)))
        else $error("result without a command or scan behind it");

    // The RAM walk runs only while triplets are being read out
    a_scan_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dtcs_pkg::ST_IDLE) |-> (phase_reg == dtcs_pkg::PH_TRIPLET))
        else $error("scan active outside triplet readout");

    // A scan is never started with no nonzero entry left to find
    a_scan_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtcs_pkg::ST_CHECK) |-> (remain_reg != '0))
        else $error("scan with no nonzero entries remaining");

    // The final report of a matrix returns the block to loading
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> (phase_reg == dtcs_pkg::PH_LOAD && loaded_reg == '0))
        else $error("final report without restart");

endmodule

`default_nettype wire

// File: sim/dense_to_coordinate_sparse_unit_tb.sv
// ----------------------------------------------------------------------------
// dense_to_coordinate_sparse_unit_tb
// Loads dense matrices of many shapes and zero densities into the unit,
// pulls back the coordinate list or the not-sparse report, and checks each
// result against a cycle-free model of the readout kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_to_coordinate_sparse_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1750;
    // rough item count of the closing tall matrix
    localparam int TAIL_ITEMS  = 650;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int CFG_W       = dtcs_pkg::CFG_W;
    localparam int IDX_W       = dtcs_pkg::IDX_W;

    // One result as it leaves the result channel
    typedef struct packed {
        dtcs_pkg::dtcs_kind_t kind;
        logic [6:0]           row;
        logic [6:0]           col;
        logic [31:0]          value;
        logic                 last;
    } coo_result_t;

    // ------------------------------------------------------------------------
    // Readout tracker: mirrors registers, element memory and readout phase,
    // and queues the result that each accepted command should produce.
    // ------------------------------------------------------------------------
    class coo_tracker;
        logic [CFG_W-1:0]      row_reg;
        logic [CFG_W-1:0]      col_reg;
        logic [31:0]           element_mem [dtcs_pkg::STORE_DEPTH];
        int unsigned           loaded;
        int unsigned           zeros;
        int unsigned           scan_pos;
        dtcs_pkg::dtcs_phase_t phase;
        coo_result_t           pending [$];
        int unsigned           error_count;

        function new();
            row_reg     = 7'd1;
            col_reg     = 7'd1;
            error_count = 0;
            restart();
        endfunction

        function void restart();
            loaded   = 0;
            zeros    = 0;
            scan_pos = 0;
            phase    = dtcs_pkg::PH_LOAD;
        endfunction

        function int unsigned effective_dim(logic [CFG_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (int'(raw) > dtcs_pkg::MAX_DIM)
                return dtcs_pkg::MAX_DIM;
            return int'(raw);
        endfunction

        function int unsigned rows();
            return effective_dim(row_reg);
        endfunction

        function int unsigned cols();
            return effective_dim(col_reg);
        endfunction

        function void write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == dtcs_pkg::REG_ROW_COUNT)
                row_reg = data;
            else
                col_reg = data;
            restart();
        endfunction

        function int unsigned next_nonzero(int unsigned p, int unsigned lim);
            while (p < lim && element_mem[p] == 32'd0)
                p++;
            return p;
        endfunction

        function void push(dtcs_pkg::dtcs_kind_t k, int unsigned r, int unsigned c,
                           logic [31:0] v, logic l);
            coo_result_t res;
            res.kind  = k;
            res.row   = r[6:0];
            res.col   = c[6:0];
            res.value = v;
            res.last  = l;
            pending.push_back(res);
        endfunction

        // Advance the model by one accepted command transfer
        function void note_command(logic cmd, logic [31:0] value);
            int unsigned total;
            int unsigned nz;
            int unsigned nxt;
            total = rows() * cols();
            if (cmd == dtcs_pkg::CMD_LOAD)
            begin
                if (phase != dtcs_pkg::PH_LOAD)
                    return;
                element_mem[loaded] = value;
                if (value == 32'd0)
                    zeros++;
                loaded++;
                if (loaded >= total)
                    phase = (zeros >= total / 2) ? dtcs_pkg::PH_HEADER
                                                 : dtcs_pkg::PH_NOT_SPARSE;
                return;
            end
            case (phase)
                dtcs_pkg::PH_HEADER:
                begin
                    nz = total - zeros;
                    if (nz == 0)
                    begin
                        push(dtcs_pkg::KIND_HEADER, rows(), cols(), 32'd0, 1'b1);
                        restart();
                    end
                    else
                    begin
                        push(dtcs_pkg::KIND_HEADER, rows(), cols(), nz, 1'b0);
                        scan_pos = next_nonzero(0, total);
                        phase    = dtcs_pkg::PH_TRIPLET;
                    end
                end
                dtcs_pkg::PH_TRIPLET:
                begin
                    nxt = next_nonzero(scan_pos + 1, total);
                    push(dtcs_pkg::KIND_TRIPLET, scan_pos / cols(), scan_pos % cols(),
                         element_mem[scan_pos], nxt >= total);
                    if (nxt >= total)
                        restart();
                    else
                        scan_pos = nxt;
                end
                dtcs_pkg::PH_NOT_SPARSE:
                begin
                    push(dtcs_pkg::KIND_NOT_SPARSE, 0, 0, 32'd0, 1'b1);
                    restart();
                end
                default: push(dtcs_pkg::KIND_NOT_READY, 0, 0, 32'd0, 1'b0);
            endcase
        endfunction

        // Compare one result transfer with the oldest queued one
        function void check_result(coo_result_t got);
            coo_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: kind %0d row %0d column %0d value %0h",
                       got.kind, got.row, got.col, got.value);
                error_count++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                error_count++;
            end
            if (got.row !== want.row)
            begin
                $error("row_field: expected %0d, got %0d", want.row, got.row);
                error_count++;
            end
            if (got.col !== want.col)
            begin
                $error("column_field: expected %0d, got %0d", want.col, got.col);
                error_count++;
            end
            if (got.value !== want.value)
            begin
                $error("value_field: expected %h, got %h", want.value, got.value);
                error_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                error_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     start         = 1'b0;
    logic                     busy;
    logic                     command       = dtcs_pkg::CMD_LOAD;
    logic signed [31:0]       element_value = '0;
    logic                     done;
    logic [1:0]               kind;
    logic [6:0]               row_field;
    logic [6:0]               column_field;
    logic signed [31:0]       value_field;
    logic                     last;
    logic                     cfg_write     = 1'b0;
    logic [IDX_W-1:0]         cfg_index     = dtcs_pkg::REG_ROW_COUNT;
    logic [CFG_W-1:0]         cfg_data      = '0;

    coo_tracker  tracker = new();
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;

    dense_to_coordinate_sparse_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .element_value(element_value),
        .done         (done),
        .kind         (kind),
        .row_field    (row_field),
        .column_field (column_field),
        .value_field  (value_field),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Check every result transfer; done is a one-cycle strobe, sampled at
    // the edge that closes its cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            tracker.check_result(coo_result_t'{dtcs_pkg::dtcs_kind_t'(kind), row_field,
                                               column_field, value_field, last});
    end

    // Watchdog: drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Hold one command on the channel until the transfer happens. Start is
    // left high so a following command can go back to back.
    task automatic send_item(input logic cmd, input logic [31:0] value);
        bit counted;
        start         <= 1'b1;
        command       <= cmd;
        element_value <= value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // a load during readout is ignored by the block and does not count
        counted = !(cmd == dtcs_pkg::CMD_LOAD && tracker.phase != dtcs_pkg::PH_LOAD);
        tracker.note_command(cmd, value);
        if (counted)
            items_sent++;
    endtask

    // Sender pacing: bursts of random length with gaps between them, so start
    // never drops and rises in the same step
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(12, 1);
        end
    endtask

    // Drain: drop start, wait out every pending result plus the latency of a
    // trailing load, which produces nothing to wait on
    task automatic settle();
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] cols_raw);
        settle();
        write_register(dtcs_pkg::REG_ROW_COUNT, rows_raw);
        write_register(dtcs_pkg::REG_COLUMN_COUNT, cols_raw);
    endtask

    function automatic logic [31:0] pick_element(input int unsigned zero_pct);
        if ($urandom_range(99, 0) < zero_pct)
            return 32'd0;
        case ($urandom_range(3, 0))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(18, 0)) - 9);
            2:       return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'd1;
        endcase
    endfunction

    // Load one matrix with stray pulls mixed in, then pull it all back out with
    // stray loads mixed in. Optionally abandon the load by rewriting a register.
    task automatic run_matrix(input int unsigned zero_pct, input bit allow_abort);
        int unsigned      r;
        logic [IDX_W-1:0] idx;
        while (tracker.phase == dtcs_pkg::PH_LOAD)
        begin
            r = $urandom_range(999, 0);
            if (allow_abort && r < 8)
            begin
                settle();
                idx = $urandom_range(1, 0) ? dtcs_pkg::REG_COLUMN_COUNT
                                           : dtcs_pkg::REG_ROW_COUNT;
                write_register(idx, (idx == dtcs_pkg::REG_ROW_COUNT) ? tracker.row_reg
                                                                     : tracker.col_reg);
                return;
            end
            if (r < 50)
                send_item(dtcs_pkg::CMD_PULL, $urandom);
            else
                send_item(dtcs_pkg::CMD_LOAD, pick_element(zero_pct));
            pace();
        end
        while (tracker.phase != dtcs_pkg::PH_LOAD)
        begin
            if ($urandom_range(99, 0) < 5)
            begin
                send_item(dtcs_pkg::CMD_LOAD, $urandom);
                pace();
            end
            send_item(dtcs_pkg::CMD_PULL, $urandom);
            pace();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] rows_raw;
        logic [CFG_W-1:0] cols_raw;
        int unsigned      r;
        int unsigned      density;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, back to back. Registers reset to a 1x1 matrix.
        send_item(dtcs_pkg::CMD_PULL, 32'd0);          // pull while loading: not ready
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);          // all-zero matrix, sparse
        send_item(dtcs_pkg::CMD_LOAD, 32'd5);          // load during readout: ignored
        send_item(dtcs_pkg::CMD_PULL, 32'hFFFF_FFFF);  // header of an empty list, last
        send_item(dtcs_pkg::CMD_PULL, 32'd0);          // back to loading: not ready
        send_item(dtcs_pkg::CMD_LOAD, 32'h7FFF_FFFF);  // no zeros, still sparse at 1x1
        send_item(dtcs_pkg::CMD_PULL, 32'd0);
        send_item(dtcs_pkg::CMD_PULL, 32'd0);
        send_item(dtcs_pkg::CMD_LOAD, 32'h8000_0000);
        send_item(dtcs_pkg::CMD_PULL, 32'd0);
        send_item(dtcs_pkg::CMD_PULL, 32'd0);

        set_shape(7'd2, 7'd2);
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_LOAD, 32'd3);
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_PULL, 32'd0);          // header 2x2, one nonzero
        send_item(dtcs_pkg::CMD_PULL, 32'd0);          // skips two zeros, last triplet
        send_item(dtcs_pkg::CMD_LOAD, 32'd1);
        send_item(dtcs_pkg::CMD_LOAD, 32'd2);
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_LOAD, 32'hFFFF_FFFF);  // one zero of four: not sparse
        send_item(dtcs_pkg::CMD_PULL, 32'd0);

        // Abandon a half-loaded matrix; a zero row count acts as one
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_LOAD, 32'd4);
        set_shape(7'd0, 7'd3);
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_LOAD, 32'd9);
        send_item(dtcs_pkg::CMD_LOAD, 32'd0);
        send_item(dtcs_pkg::CMD_PULL, 32'd0);
        send_item(dtcs_pkg::CMD_PULL, 32'd0);

        // Random matrices, mostly small; some long thin ones and
        // out-of-range register values
        while (items_sent + TAIL_ITEMS < ITEM_TARGET)
        begin
            r = $urandom_range(99, 0);
            if (r < 70)
            begin
                rows_raw = CFG_W'($urandom_range(6, 1));
                cols_raw = CFG_W'($urandom_range(6, 1));
            end
            else if (r < 85)
            begin
                rows_raw = CFG_W'($urandom_range(64, 7));
                cols_raw = CFG_W'($urandom_range(2, 1));
                if ($urandom_range(1, 0))
                    {rows_raw, cols_raw} = {cols_raw, rows_raw};
            end
            else
            begin
                rows_raw = $urandom_range(1, 0) ? 7'd0 : CFG_W'($urandom_range(127, 65));
                cols_raw = CFG_W'($urandom_range(2, 0));
                if ($urandom_range(1, 0))
                    {rows_raw, cols_raw} = {cols_raw, rows_raw};
            end
            case ($urandom_range(4, 0))
                0:       density = 0;
                1:       density = 35;
                2:       density = 50;
                3:       density = 75;
                default: density = 100;
            endcase
            set_shape(rows_raw, cols_raw);
            run_matrix(density, 1'b1);
        end

        // One tall matrix, row count above the maximum
        set_shape(7'd127, 7'd8);
        run_matrix(80, 1'b0);

        settle();
        repeat (20) @(posedge clk);
        if (tracker.error_count == 0 && tracker.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/dtcs_pkg.sv
hw/rtl/dtcs_ram.sv
hw/rtl/dtcs_cfg.sv
hw/rtl/dense_to_coordinate_sparse_unit.sv
sim/dense_to_coordinate_sparse_unit_tb.sv
